[src/signed_integer_base_digit_encoder_assert.svh]
// Assertion macros shared by the encoder RTL.
`ifndef SIGNED_INTEGER_BASE_DIGIT_ENCODER_ASSERT_SVH
`define SIGNED_INTEGER_BASE_DIGIT_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SIBDE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SIBDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/sibde_pkg.sv]
// Types and constants shared by the signed integer digit encoder.
package sibde_pkg;

    localparam int MOD_W      = 32;
    localparam int BASE_W     = 16;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [MOD_W-1:0]  MOD_RESET  = 32'd256;
    localparam logic [BASE_W-1:0] BASE_RESET = 16'd2;
    localparam logic [BASE_W-1:0] BASE_MIN   = 16'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLAIN_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_BASE    = 2'd1;

    typedef enum logic
    {
        ST_IDLE,
        ST_DIV
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed
    {
        logic done;
        logic running;
    } div_stat_t;

endpackage

[src/signed_integer_base_digit_encoder.sv]
// Top level of the signed integer base-b digit encoder.
//
//  channel   handshake            payload                          direction
//  ------    -------------------  -------------------------------  ---------
//  input     start / busy         value                            in
//  result    coeff_strobe         coeff_index, coeff_value, last   out
//  config    wr_en                wr_index, wr_data                in
//
// A word is accepted when start is high and busy is low; busy then stays high
// until the last digit has been sent. Each digit takes one pass through the
// shared bit-serial divider, so an item of n digits takes n passes
// (n = 1 for zero, up to VALUE_WIDTH for base 2).
// Each result word is shown for exactly one cycle on coeff_strobe; the
// receiver cannot stall it. Reset is asynchronous, active low, and restores
// plain_modulus = 256 and digit_base = 2.
module signed_integer_base_digit_encoder #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [VALUE_WIDTH-1:0]     value,
    input  logic                              wr_en,
    input  logic [sibde_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [sibde_pkg::CFG_DATA_W-1:0]  wr_data,
    output logic                              coeff_strobe,
    output logic [sibde_pkg::IDX_W-1:0]       coeff_index,
    output logic [sibde_pkg::MOD_W-1:0]       coeff_value,
    output logic                              last
);
    import sibde_pkg::*;

    // Configuration registers
    logic [MOD_W-1:0]  plain_modulus_reg;
    logic [BASE_W-1:0] digit_base_reg;

    // Sequencer
    state_t            state_reg, state_next;
    logic              neg_reg;
    logic [IDX_W-1:0]  digit_idx_reg;

    // Result word registers
    logic              strobe_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [MOD_W-1:0]  value_reg;
    logic              last_reg;

    // Divider connection
    logic                   accept;
    logic                   div_load;
    logic                   emit;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [BASE_W-1:0]      eff_base;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [BASE_W-1:0]      remainder;
    div_stat_t              div_stat;
    logic                   final_digit;
    logic [MOD_W-1:0]       digit_ext;
    logic [MOD_W-1:0]       coeff;

    // Take the magnitude; the most negative value maps to 2^(VALUE_WIDTH-1)
    // and still fits as an unsigned word.
    assign magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

    // Treat a base of zero or one as two
    assign eff_base = (digit_base_reg < BASE_MIN) ? BASE_MIN : digit_base_reg;

    assign accept = start && (state_reg == ST_IDLE);

    // Digit done: the quotient feeds the next division unless it is zero
    assign final_digit  = (quotient == '0);
    assign digit_ext    = {{(MOD_W - BASE_W){1'b0}}, remainder};
    assign coeff        = (neg_reg && remainder != '0) ? (plain_modulus_reg - digit_ext)
                                                       : digit_ext;
    assign div_dividend = accept ? magnitude : quotient;

    sibde_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (div_dividend),
        .divisor  (eff_base),
        .quotient (quotient),
        .remainder(remainder),
        .stat     (div_stat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done && final_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        div_load = 1'b0;
        emit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                div_load = start;
            end
            ST_DIV:
            begin
                emit     = div_stat.done;
                div_load = div_stat.done && !final_digit;
            end
            default:
            begin
                div_load = 1'b0;
                emit     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            strobe_reg        <= 1'b0;
            plain_modulus_reg <= MOD_RESET;
            digit_base_reg    <= BASE_RESET;
            digit_idx_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit;
            // Advance the digit position on every emitted word
            if (accept)
            begin
                digit_idx_reg <= '0;
            end
            else if (emit)
            begin
                digit_idx_reg <= digit_idx_reg + 1'b1;
            end
            // Drop writes to unknown indexes
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_PLAIN_MODULUS: plain_modulus_reg <= wr_data;
                    REG_DIGIT_BASE:    digit_base_reg    <= wr_data[BASE_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Hold sign and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= value[VALUE_WIDTH-1];
        end
        if (emit)
        begin
            index_reg <= digit_idx_reg;
            value_reg <= coeff;
            last_reg  <= final_digit;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign coeff_strobe = strobe_reg;
    assign coeff_index  = index_reg;
    assign coeff_value  = value_reg;
    assign last         = last_reg;

`include "signed_integer_base_digit_encoder_assert.svh"

    `SIBDE_ASSERT_IMPL(a_last_frees_block, clk, rst_n, coeff_strobe && last, !busy)
    `SIBDE_ASSERT_IMPL(a_more_digits_busy, clk, rst_n, coeff_strobe && !last, busy)
    `SIBDE_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `SIBDE_ASSERT_IMPL(a_emit_from_divider, clk, rst_n, emit, div_stat.done && !div_stat.running)

endmodule

[src/sibde_divider.sv]
// Radix-2 restoring divider: one quotient bit per cycle, 16-bit divisor.
module sibde_divider #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [VALUE_WIDTH-1:0]     dividend,
    input  logic [sibde_pkg::BASE_W-1:0] divisor,
    output logic [VALUE_WIDTH-1:0]     quotient,
    output logic [sibde_pkg::BASE_W-1:0] remainder,
    output sibde_pkg::div_stat_t       stat
);
    import sibde_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [BASE_W-1:0]      rem_reg, rem_next;
    logic [BASE_W-1:0]      divisor_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   running_reg;
    logic                   done_reg;
    logic [BASE_W:0]        r_shift;
    logic [BASE_W:0]        r_diff;
    logic                   ge;

    // Shift in the next dividend bit and try the subtraction
    assign r_shift  = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign r_diff   = r_shift - {1'b0, divisor_reg};
    assign ge       = (r_shift >= {1'b0, divisor_reg});
    assign rem_next = ge ? r_diff[BASE_W-1:0] : r_shift[BASE_W-1:0];
    assign quo_next = {quo_reg[VALUE_WIDTH-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                running_reg <= 1'b1;
                cnt_reg     <= CNT_W'(VALUE_WIDTH - 1);
            end
            else if (running_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (running_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient     = quo_reg;
    assign remainder    = rem_reg;
    assign stat.done    = done_reg;
    assign stat.running = running_reg;

`include "signed_integer_base_digit_encoder_assert.svh"

    `SIBDE_ASSERT_IMPL(a_done_not_running, clk, rst_n, done_reg, !running_reg)
    `SIBDE_ASSERT_NEXT(a_last_step_done, clk, rst_n, running_reg && !load && cnt_reg == '0, done_reg)
    `SIBDE_ASSERT_IMPL(a_rem_below_divisor, clk, rst_n, done_reg, rem_reg < divisor_reg)

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the signed integer base-b digit encoder.
`timescale 1ns / 100ps

module tb_top;
    import sibde_pkg::*;

    localparam int VALUE_W = 64;
    localparam int DIGIT_CYCLES = VALUE_W + 1;

    // Register indexes that map to nothing; writes there must leave both registers alone
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    // One coefficient word as the block presents it
    typedef struct packed
    {
        logic [IDX_W-1:0] index;
        logic [MOD_W-1:0] coeff;
        logic             is_last;
    } coeff_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      wr_index = '0;
    logic [CFG_DATA_W-1:0]     wr_data = '0;
    logic                      coeff_strobe;
    logic [IDX_W-1:0]          coeff_index;
    logic [MOD_W-1:0]          coeff_value;
    logic                      coeff_last;

    // Local copy of the two registers, updated at the edge that writes them
    logic [MOD_W-1:0]  modulus_reg = MOD_RESET;
    logic [BASE_W-1:0] radix_reg = BASE_RESET;

    // Coefficient words predicted for accepted integers, oldest first
    coeff_word_t pending_coeffs[$];

    int error_count = 0;
    int words_sent = 0;
    int coeffs_checked = 0;
    int settings_used = 1;

    signed_integer_base_digit_encoder #(
        .VALUE_WIDTH(VALUE_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .coeff_strobe (coeff_strobe),
        .coeff_index  (coeff_index),
        .coeff_value  (coeff_value),
        .last         (coeff_last)
    );

    always #2 clk = ~clk;

    // Split one integer into its radix digits, lowest first, and queue the
    // coefficient words the block must produce for it. A negative integer
    // negates each nonzero digit modulo 2^32 against the plain modulus.
    function automatic void encode_digits(input logic [VALUE_W-1:0] word);
        logic               negative;
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [MOD_W-1:0]   digit;
        coeff_word_t        cw;
        int                 n;
        negative = word[VALUE_W-1];
        // Two's complement negate; the most negative word maps onto itself,
        // which read unsigned is exactly its magnitude
        mag = negative ? -word : word;
        // A base of zero or one falls back to binary
        radix = (radix_reg < BASE_MIN) ? VALUE_W'(BASE_MIN) : VALUE_W'(radix_reg);
        if (mag == '0)
        begin
            cw.index = '0;
            cw.coeff = '0;
            cw.is_last = 1'b1;
            pending_coeffs.push_back(cw);
            return;
        end
        n = 0;
        while (mag != '0 && n < 64)
        begin
            digit = MOD_W'(mag % radix);
            mag = mag / radix;
            cw.index = IDX_W'(n);
            // Zero digits stay zero even for negative integers
            cw.coeff = (negative && digit != '0) ? modulus_reg - digit : digit;
            cw.is_last = (mag == '0);
            pending_coeffs.push_back(cw);
            n++;
        end
    endfunction

    // Offer one integer after an idle gap and hold it until accepted. With no
    // gap, start simply stays high from the previous word.
    task automatic send_word(input logic [VALUE_W-1:0] word, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= word;
        do
            @(posedge clk);
        while (busy);
        encode_digits(word);
        words_sent++;
    endtask

    // Drop start and wait until every predicted word has come back and the
    // block reports idle, then let a few more cycles pass.
    task automatic wait_idle(input int settle);
        start <= 1'b0;
        do
            @(posedge clk);
        while (busy || pending_coeffs.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Write one register; keep the enable high when another write follows at
    // once so it is never dropped and raised in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data,
                             input bit keep_enable);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        if (idx == REG_PLAIN_MODULUS)
            modulus_reg = data;
        else if (idx == REG_DIGIT_BASE)
            radix_reg = data[BASE_W-1:0];
        if (!keep_enable)
            wr_en <= 1'b0;
    endtask

    // Program modulus and base back to back; the upper data bits of the base
    // write are junk that the register must drop.
    task automatic apply_setting(input logic [MOD_W-1:0] modulus,
                                 input logic [BASE_W-1:0] radix,
                                 input logic [CFG_DATA_W-BASE_W-1:0] junk);
        write_reg(REG_PLAIN_MODULUS, modulus, 1'b1);
        write_reg(REG_DIGIT_BASE, {junk, radix}, 1'b0);
        settings_used++;
    endtask

    // Draw a random integer, mostly short magnitudes so binary runs stay cheap
    function automatic logic [VALUE_W-1:0] draw_value();
        int                 pick;
        int                 bits;
        logic [VALUE_W-1:0] mag;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return '0;
        if (pick < 7)
            return {1'b1, {(VALUE_W-1){1'b0}}};
        if (pick < 72)
            bits = $urandom_range(1, 16);
        else if (pick < 90)
            bits = $urandom_range(17, 40);
        else
            bits = $urandom_range(41, VALUE_W);
        mag = {$urandom, $urandom};
        if (bits < VALUE_W)
            mag = mag & ((VALUE_W'(1) << bits) - 1);
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    // Out of reset: modulus 256, binary digits
    task automatic test_reset_defaults();
        send_word('0, $urandom_range(0, 4));
        send_word(64'd1, $urandom_range(0, 4));
        send_word(-64'd1, $urandom_range(0, 4));
        send_word(64'h7FFF_FFFF_FFFF_FFFF, $urandom_range(0, 4));
        send_word(64'h8000_0000_0000_0000, $urandom_range(0, 4));
        // zero digit among negated ones
        send_word(-64'd6, $urandom_range(0, 4));
    endtask

    // Widest base and modulus, degenerate bases, base above modulus, tiny moduli
    task automatic test_radix_extremes();
        wait_idle(4);
        apply_setting(32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_word(64'h8000_0000_0000_0000, 0);
        send_word(-64'd458745, $urandom_range(0, 4));
        send_word(64'd65535, 0);

        // base zero and base one both act as binary
        wait_idle(4);
        apply_setting(32'd256, 16'd0, 16'hFFFF);
        send_word(-64'd5, $urandom_range(0, 4));
        send_word(64'd12, 0);
        wait_idle(4);
        apply_setting(32'd256, 16'd1, 16'hA5A5);
        send_word(64'd9, $urandom_range(0, 4));

        // base above modulus: negated digits wrap past zero
        wait_idle(4);
        apply_setting(32'd10, 16'd16, 16'h0000);
        send_word(-64'h1F3, $urandom_range(0, 4));
        send_word(64'd15, 0);

        // moduli below two are used as written
        wait_idle(4);
        apply_setting(32'd0, 16'd3, 16'h0000);
        send_word(-64'd7, $urandom_range(0, 4));
        wait_idle(4);
        apply_setting(32'd1, 16'd3, 16'h0000);
        send_word(-64'd8, $urandom_range(0, 4));
    endtask

    // Writes to unmapped indexes must not disturb either register
    task automatic test_unmapped_registers();
        wait_idle(4);
        apply_setting(32'd256, 16'd2, 16'h0000);
        wait_idle(2);
        write_reg(REG_UNUSED_A, 32'hFFFF_FFFF, 1'b1);
        write_reg(REG_UNUSED_B, 32'h0000_0007, 1'b0);
        send_word(-64'd1, $urandom_range(0, 4));
        send_word(64'd3, 0);
    endtask

    // Random integers under a spread of settings; every third setting
    // streams back to back with no idle gaps
    task automatic test_random_settings();
        logic [MOD_W-1:0]  modulus;
        logic [BASE_W-1:0] radix;
        int                gap;
        for (int s = 0; s < 7; s++)
        begin
            case (s)
                0: begin modulus = 32'hFFFF_FFFF; radix = 16'hFFFF; end
                1: begin modulus = 32'd2;         radix = 16'd2;    end
                2: begin modulus = 32'd257;       radix = 16'd10;   end
                3: begin modulus = 32'd65537;     radix = 16'd3;    end
                4: begin modulus = $urandom | 32'h0001_0000; radix = 16'd16; end
                default:
                begin
                    modulus = $urandom;
                    if (modulus < 2)
                        modulus = 32'd2;
                    radix = BASE_W'($urandom_range(2, (modulus > 65535) ? 65535 : modulus));
                end
            endcase
            wait_idle(4);
            apply_setting(modulus, radix, 16'($urandom));
            for (int i = 0; i < 20; i++)
            begin
                gap = (s % 3 == 0) ? 0 : $urandom_range(0, 4);
                send_word(draw_value(), gap);
            end
        end
    endtask

    // Compare each strobed coefficient word with the oldest prediction
    always @(posedge clk)
    begin : check_coeffs
        coeff_word_t want;
        if (rst_n && coeff_strobe)
        begin
            if (pending_coeffs.size() == 0)
            begin
                $error("unexpected coefficient word: index %0d value %0d last %0b",
                       coeff_index, coeff_value, coeff_last);
                error_count++;
            end
            else
            begin
                want = pending_coeffs.pop_front();
                coeffs_checked++;
                if (coeff_index !== want.index)
                begin
                    $error("coeff_index: expected %0d, got %0d", want.index, coeff_index);
                    error_count++;
                end
                if (coeff_value !== want.coeff)
                begin
                    $error("coeff_value: expected %0d, got %0d", want.coeff, coeff_value);
                    error_count++;
                end
                if (coeff_last !== want.is_last)
                begin
                    $error("last: expected %0b, got %0b", want.is_last, coeff_last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        // hold reset low from time zero, then release it on an edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_radix_extremes();
        test_unmapped_registers();
        test_random_settings();

        // let a settle time pass after the last word before judging
        wait_idle(2 * DIGIT_CYCLES);
        if (pending_coeffs.size() != 0)
        begin
            $error("%0d predicted coefficient words never arrived", pending_coeffs.size());
            error_count++;
        end
        $display("covered %0d integers and %0d coefficient words over %0d register settings",
                 words_sent, coeffs_checked, settings_used);
        $display("mismatches: %0d", error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hung block: far beyond 170 words of 64 binary digits each
    initial
    begin
        #20_000_000;
        $display("timeout: encoder did not finish");
        $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/sibde_pkg.sv
src/sibde_divider.sv
src/signed_integer_base_digit_encoder.sv
bench/tb_top.sv
